>>> src/swmq_pkg.sv
// Shared types and constants for the stack with minimum query.
// No dependencies; imported by the top level.
package swmq_pkg;

  typedef logic [1:0]         opcode_t;
  typedef logic signed [31:0] word_t;

  localparam opcode_t OP_NOP  = 2'd0;
  localparam opcode_t OP_PUSH = 2'd1;
  localparam opcode_t OP_POP  = 2'd2;

  // Start value of the minimum scan and the minimum of an empty stack
  localparam word_t MIN_START = 32'sd32767;

  localparam int FILL_COUNT_W = 5;

endpackage

>>> src/swmq_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies; used by the top level as the entry store.
module swmq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> src/stack_with_min_query_unit.sv
// Stack of signed words with a minimum query over all stored words.
// Each accepted item is followed by a scan that reads the entries up to the fill level after
// the operation, one entry a cycle through the single RAM port into one comparator; no new
// item is taken until its result has gone to the output register, so the time per item grows
// with the fill level. A result still waiting holds the next one in the last step.
// Reset (rst_n low, synchronous) empties the stack; entry contents are not cleared.
module stack_with_min_query_unit #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  swmq_pkg::opcode_t  in_opcode,
  input  swmq_pkg::word_t    in_push_value,
  output logic               out_valid,
  input  logic               out_ready,
  output swmq_pkg::word_t    out_top_value,
  output logic               out_is_empty,
  output logic               out_is_full,
  output logic [4:0]         out_fill_count,
  output swmq_pkg::word_t    out_min_value,
  output logic               out_op_error
);
  import swmq_pkg::*;

  localparam int AW    = $clog2(DEPTH);
  localparam int LVL_W = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

  state_t            state_r, state_nxt;
  logic [LVL_W-1:0]  fill_r, fill_nxt;
  logic [LVL_W-1:0]  idx_r, idx_nxt;
  logic              rv_r, rv_nxt;
  logic              err_r, err_nxt;
  word_t             min_r, min_nxt;
  word_t             top_r, top_nxt;
  logic              out_valid_r, out_valid_nxt;
  word_t             out_top_r, out_top_nxt;
  word_t             out_min_r, out_min_nxt;
  logic              out_empty_r, out_empty_nxt;
  logic              out_full_r, out_full_nxt;
  logic              out_err_r, out_err_nxt;
  logic [4:0]        out_cnt_r, out_cnt_nxt;

  logic              in_fire;
  logic              out_free;
  logic              issue;
  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  word_t             ram_rdata;
  logic [31:0]       fill_ext;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign issue    = (state_r == ST_SCAN) && (idx_r < fill_r);
  assign fill_ext = 32'(fill_r);

  // Write on an accepted push with room, otherwise read the scan index
  always_comb begin
    ram_we   = 1'b0;
    ram_addr = idx_r[AW-1:0];
    if (in_fire && (in_opcode == OP_PUSH) && (fill_r < LVL_W'(DEPTH))) begin
      ram_we   = 1'b1;
      ram_addr = fill_r[AW-1:0];
    end
  end

  swmq_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_push_value),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    idx_nxt       = idx_r;
    rv_nxt        = issue;
    err_nxt       = err_r;
    min_nxt       = min_r;
    top_nxt       = top_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_top_nxt   = out_top_r;
    out_min_nxt   = out_min_r;
    out_empty_nxt = out_empty_r;
    out_full_nxt  = out_full_r;
    out_err_nxt   = out_err_r;
    out_cnt_nxt   = out_cnt_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          err_nxt = 1'b0;
          case (in_opcode)
            OP_PUSH: begin
              if (fill_r < LVL_W'(DEPTH)) fill_nxt = fill_r + LVL_W'(1);
              else                        err_nxt  = 1'b1;
            end
            OP_POP: begin
              if (fill_r != '0) fill_nxt = fill_r - LVL_W'(1);
              else              err_nxt  = 1'b1;
            end
            default: ;
          endcase
          idx_nxt   = '0;
          min_nxt   = MIN_START;
          top_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (issue) idx_nxt = idx_r + LVL_W'(1);
        if (rv_r) begin
          if (ram_rdata < min_r) min_nxt = ram_rdata;
          // last read data belongs to the top entry
          if (idx_r == fill_r) top_nxt = ram_rdata;
        end
        if (!issue && !rv_r) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_top_nxt   = top_r;
          out_min_nxt   = min_r;
          out_empty_nxt = (fill_r == '0);
          out_full_nxt  = (fill_r == LVL_W'(DEPTH));
          out_err_nxt   = err_r;
          out_cnt_nxt   = fill_ext[FILL_COUNT_W-1:0];
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      idx_r       <= '0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      idx_r       <= idx_nxt;
      rv_r        <= rv_nxt;
      out_valid_r <= out_valid_nxt;
    end
    err_r       <= err_nxt;
    min_r       <= min_nxt;
    top_r       <= top_nxt;
    out_top_r   <= out_top_nxt;
    out_min_r   <= out_min_nxt;
    out_empty_r <= out_empty_nxt;
    out_full_r  <= out_full_nxt;
    out_err_r   <= out_err_nxt;
    out_cnt_r   <= out_cnt_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_top_value  = out_top_r;
  assign out_min_value  = out_min_r;
  assign out_is_empty   = out_empty_r;
  assign out_is_full    = out_full_r;
  assign out_fill_count = out_cnt_r;
  assign out_op_error   = out_err_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= LVL_W'(DEPTH))
    else $error("fill level beyond depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("item accepted while previous item in progress");

  a_read_follows_issue: assert property (@(posedge clk) disable iff (!rst_n)
    rv_r |-> $past(issue))
    else $error("read data flagged without a read");

  a_error_keeps_level: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && $past(in_fire) && err_r) |-> fill_r == $past(fill_r))
    else $error("ignored operation changed the fill level");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_empty_r) |-> (out_min_r == MIN_START && out_top_r == '0))
    else $error("empty stack result carries stale top or minimum");

endmodule

>>> bench/tb_stack_with_min_query_unit.sv
// Self-checking bench for stack_with_min_query_unit: a shadow stack predicts top, flags,
// fill count, minimum and error for every accepted item, and a scoreboard checks results.
// Depends on swmq_pkg and the RTL top; drives random idling on both handshake sides.
module tb_stack_with_min_query_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import swmq_pkg::*;

  localparam int      STACK_DEPTH  = 16;
  localparam opcode_t OP_SPARE     = 2'd3;
  localparam int      RANDOM_ITEMS = 1830;
  localparam int      QUIET_ITEMS  = 200;
  localparam int      DRAIN_EVERY  = 400;
  localparam int      TAIL_CYCLES  = 30;
  localparam int      CYCLE_LIMIT  = 400000;

  typedef struct packed {
    word_t                   top_value;
    logic                    is_empty;
    logic                    is_full;
    logic [FILL_COUNT_W-1:0] fill_count;
    word_t                   min_value;
    logic                    op_error;
  } stack_status_t;

  class stack_scoreboard;
    word_t         shadow_words [STACK_DEPTH];
    int            shadow_fill;
    stack_status_t status_q [$];
    int            mismatches;

    function new();
      shadow_fill = 0;
      mismatches  = 0;
    endfunction

    // Apply one accepted item to the shadow stack and queue the status it leads to.
    function void note_item(opcode_t op, word_t value);
      stack_status_t st;
      int            i;
      st.op_error = 1'b0;
      case (op)
        OP_PUSH: begin
          if (shadow_fill >= STACK_DEPTH) begin
            st.op_error = 1'b1;
          end else begin
            shadow_words[shadow_fill] = value;
            shadow_fill++;
          end
        end
        OP_POP: begin
          if (shadow_fill == 0) st.op_error = 1'b1;
          else shadow_fill--;
        end
        default: ;
      endcase
      st.top_value = (shadow_fill > 0) ? shadow_words[shadow_fill - 1] : word_t'(0);
      st.min_value = MIN_START;
      for (i = 0; i < shadow_fill; i++) begin
        if (shadow_words[i] < st.min_value) st.min_value = shadow_words[i];
      end
      st.is_empty   = (shadow_fill == 0);
      st.is_full    = (shadow_fill == STACK_DEPTH);
      st.fill_count = FILL_COUNT_W'(shadow_fill);
      status_q.push_back(st);
    endfunction

    function void check_result(word_t top, logic empty, logic full,
                               logic [FILL_COUNT_W-1:0] fill, word_t min_w, logic err);
      stack_status_t want;
      if (status_q.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: result with nothing outstanding: top=%0d fill=%0d min=%0d",
                   $realtime, top, fill, min_w);
        mismatches++;
        return;
      end
      want = status_q.pop_front();
      if (top !== want.top_value || empty !== want.is_empty || full !== want.is_full ||
          fill !== want.fill_count || min_w !== want.min_value || err !== want.op_error) begin
        if (mismatches < 10) begin
          $display("%0t: mismatch exp top=%0d empty=%0b full=%0b fill=%0d min=%0d err=%0b",
                   $realtime, want.top_value, want.is_empty, want.is_full,
                   want.fill_count, want.min_value, want.op_error);
          $display("%0t:          got top=%0d empty=%0b full=%0b fill=%0d min=%0d err=%0b",
                   $realtime, top, empty, full, fill, min_w, err);
        end
        mismatches++;
      end
    endfunction

    function int pending();
      return status_q.size();
    endfunction
  endclass

  logic    clk           = 1'b0;
  logic    rst_n         = 1'b0;
  logic    in_valid      = 1'b0;
  logic    in_ready;
  opcode_t in_opcode     = OP_NOP;
  word_t   in_push_value = '0;
  logic    out_valid;
  logic    out_ready     = 1'b1;
  word_t   out_top_value;
  logic    out_is_empty;
  logic    out_is_full;
  logic [4:0] out_fill_count;
  word_t   out_min_value;
  logic    out_op_error;

  logic    quiet_tail    = 1'b0;
  int      stall_left    = 0;
  int      calm_left     = 0;
  int      cycle_count   = 0;

  stack_scoreboard status_board = new();

  stack_with_min_query_unit #(.DEPTH(STACK_DEPTH)) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_push_value  (in_push_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_top_value  (out_top_value),
    .out_is_empty   (out_is_empty),
    .out_is_full    (out_is_full),
    .out_fill_count (out_fill_count),
    .out_min_value  (out_min_value),
    .out_op_error   (out_op_error)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) status_board.note_item(in_opcode, in_push_value);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      status_board.check_result(out_top_value, out_is_empty, out_is_full, out_fill_count,
                                out_min_value, out_op_error);
  end

  // Result side: random stall bursts, broken by calm stretches.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (calm_left > 0 || quiet_tail) begin
      calm_left <= (calm_left > 0) ? calm_left - 1 : 0;
      out_ready <= 1'b1;
    end else if ($urandom_range(0, 39) == 0) begin
      calm_left <= $urandom_range(30, 80);
      out_ready <= 1'b1;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 10);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Call right after a rising edge; returns at the edge where the item is taken.
  task automatic send_item(opcode_t op, word_t value);
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_push_value <= value;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic idle_sender(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Hold the input until every outstanding result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (status_board.pending() != 0);
  endtask

  function automatic opcode_t pick_opcode(int mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      0:       return (r < 72) ? OP_PUSH : (r < 88) ? OP_POP : (r < 96) ? OP_NOP : OP_SPARE;
      1:       return (r < 72) ? OP_POP : (r < 88) ? OP_PUSH : (r < 96) ? OP_NOP : OP_SPARE;
      default: return (r < 45) ? OP_PUSH : (r < 90) ? OP_POP : (r < 96) ? OP_NOP : OP_SPARE;
    endcase
  endfunction

  // Mix full-range words with values near the 32767 ceiling, small negatives and extremes.
  function automatic word_t random_word();
    case ($urandom_range(0, 7))
      1, 2:    return word_t'(32735 + $urandom_range(0, 64));
      3:       return word_t'(32'd0 - $urandom_range(0, 1000));
      4: begin
        case ($urandom_range(0, 3))
          0:       return word_t'(32'h8000_0000);
          1:       return word_t'(32'h7FFF_FFFF);
          2:       return word_t'(0);
          default: return word_t'(-1);
        endcase
      end
      default: return word_t'($urandom());
    endcase
  endfunction

  initial begin
    int  idx;
    int  n;
    int  mode;
    int  round_len;
    bit  gappy;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Empty stack: query, pop underflow, spare opcode
    send_item(OP_NOP,   word_t'(123));
    send_item(OP_POP,   word_t'(0));
    send_item(OP_SPARE, word_t'(-5));
    send_item(OP_PUSH,  word_t'(32'h7FFF_FFFF));
    send_item(OP_NOP,   word_t'(0));
    send_item(OP_PUSH,  word_t'(32768));
    send_item(OP_PUSH,  word_t'(32767));
    send_item(OP_PUSH,  word_t'(32766));
    send_item(OP_PUSH,  word_t'(0));
    send_item(OP_PUSH,  word_t'(-1));
    send_item(OP_PUSH,  word_t'(32'h8000_0000));
    send_item(OP_SPARE, word_t'(7));
    send_item(OP_POP,   word_t'(0));
    send_item(OP_POP,   word_t'(0));
    send_item(OP_POP,   word_t'(0));
    send_item(OP_PUSH,  word_t'(32'hAAAA_AAAA));
    send_item(OP_PUSH,  word_t'(32'h5555_5555));
    repeat (6) send_item(OP_POP, word_t'(0));
    send_item(OP_POP,   word_t'(0));
    drain_results();

    idx = 0;
    while (idx < RANDOM_ITEMS) begin
      mode      = $urandom_range(0, 2);
      round_len = $urandom_range(8, 40);
      gappy     = ($urandom_range(0, 2) != 0);
      for (n = 0; n < round_len && idx < RANDOM_ITEMS; n++) begin
        if (idx >= RANDOM_ITEMS - QUIET_ITEMS) quiet_tail <= 1'b1;
        else if (gappy && $urandom_range(0, 3) == 0) idle_sender($urandom_range(1, 11));
        send_item(pick_opcode(mode), random_word());
        idx++;
        if (idx % DRAIN_EVERY == 0) drain_results();
      end
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (status_board.pending() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (status_board.mismatches == 0 && status_board.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
